### hdl/mzrp_pkg.sv
package mzrp_pkg;

  localparam int ALPHABET_SIZE  = 256;
  localparam int RUN_COUNT_BITS = 32;

  localparam int SYM_W   = 8;
  localparam int POS_W   = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int RUN_V_W = RUN_COUNT_BITS + 1;
  localparam int DIG_W   = $clog2(RUN_COUNT_BITS + 1);
  localparam int SH_W    = $clog2(RUN_V_W + 1);
  localparam int CODE_W  = 64;
  localparam int LEN_W   = 7;

  // Run value (count plus one) once the counter has reached its limit.
  localparam logic [RUN_V_W-1:0] RUN_FULL = {1'b1, {RUN_COUNT_BITS{1'b0}}};

  typedef struct packed {
    logic move;
    logic restore;
  } list_ctrl_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  length;
    logic              is_run;
    logic              sat;
  } code_word_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOVE  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_GAMMA = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

endpackage

### hdl/mzrp_cell.sv
module mzrp_cell
  import mzrp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  list_ctrl_t       ctrl,
  input  logic [POS_W-1:0] home,
  input  logic [POS_W-1:0] pos,
  input  logic [SYM_W-1:0] cmp_sym,
  input  logic [SYM_W-1:0] prev_entry,
  output logic [SYM_W-1:0] entry,
  output logic             match
);

  // Every cell at or in front of the found position takes its neighbour's entry.
  always_ff @(posedge clk) begin
    if (rst || ctrl.restore) begin
      entry <= SYM_W'(home);
    end else if (ctrl.move && (home <= pos)) begin
      entry <= prev_entry;
    end
  end

  assign match = (entry == cmp_sym);

endmodule

### hdl/mzrp_list.sv
module mzrp_list
  import mzrp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  list_ctrl_t       ctrl,
  input  logic [POS_W-1:0] pos,
  input  logic [SYM_W-1:0] cmp_sym,
  input  logic [SYM_W-1:0] ins_sym,
  output logic             found,
  output logic [POS_W-1:0] match_pos
);

  logic [SYM_W-1:0]         entries [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] hits;

  for (genvar j = 0; j < ALPHABET_SIZE; j++) begin : g_cell
    logic [SYM_W-1:0] prev;
    if (j == 0) begin : g_front
      assign prev = ins_sym;
    end else begin : g_body
      assign prev = entries[j-1];
    end
    mzrp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .home       (POS_W'(j)),
      .pos        (pos),
      .cmp_sym    (cmp_sym),
      .prev_entry (prev),
      .entry      (entries[j]),
      .match      (hits[j])
    );
  end

  // The list is a permutation, so at most one cell matches.
  always_comb begin
    match_pos = '0;
    for (int j = 0; j < ALPHABET_SIZE; j++) begin
      if (hits[j]) begin
        match_pos = match_pos | POS_W'(j);
      end
    end
  end

  assign found = |hits;

endmodule

### hdl/mzrp_coder.sv
module mzrp_coder
  import mzrp_pkg::*;
(
  input  logic [RUN_V_W-1:0] run_value,
  input  logic [DIG_W-1:0]   run_digits,
  input  logic               run_over,
  input  logic [POS_W-1:0]   pos,
  output code_word_t         run_word,
  output code_word_t         gamma_word
);

  logic [RUN_V_W-1:0] rev;
  logic [RUN_V_W-1:0] lane;
  logic [SH_W-1:0]    sh;
  logic [POS_W:0]     gv;
  logic [LEN_W-1:0]   nb;

  // The least significant digit of the run value goes out first, so it sits
  // highest in the word: reverse the value and drop the unused top.
  always_comb begin
    for (int i = 0; i < RUN_V_W; i++) begin
      rev[i] = run_value[RUN_V_W-1-i];
    end
    sh   = SH_W'(RUN_V_W) - SH_W'(run_digits);
    lane = rev >> sh;
  end

  always_comb begin
    run_word = '0;
    for (int k = 0; k < RUN_COUNT_BITS; k++) begin
      run_word.bits[2*k+1] = (SH_W'(k) < SH_W'(run_digits));
      run_word.bits[2*k]   = lane[k];
    end
    run_word.length = LEN_W'({run_digits, 1'b0});
    run_word.is_run = 1'b1;
    run_word.sat    = run_over;
  end

  always_comb begin
    gv = (POS_W+1)'(pos) + (POS_W+1)'(1);
    nb = '0;
    for (int i = 0; i <= POS_W; i++) begin
      if (gv[i]) begin
        nb = LEN_W'(i + 1);
      end
    end
    gamma_word        = '0;
    gamma_word.bits   = CODE_W'(gv);
    gamma_word.length = LEN_W'({nb, 1'b0}) - LEN_W'(1);
    gamma_word.is_run = 1'b0;
    gamma_word.sat    = 1'b0;
  end

endmodule

### hdl/mtf_zero_run_prefix_encoder_top.sv
// Move-to-front coder with zero-run and Elias gamma coding. Each symbol is
// compared against every entry of a row of list cells in the cycle it is
// accepted; in the next cycle the row shifts by one cell towards the found
// position and the symbol drops into the front cell. An item that sends no
// code needs only that compare-then-shift pair; the gamma code and any run
// code ahead of it each go out from a state of their own, and an
// end-of-block item passes through one more state, flushing the run and
// restoring the list. A finished code word waits in the output register,
// and the next transaction can be accepted while it does.
module mtf_zero_run_prefix_encoder_top
  import mzrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SYM_W-1:0]  symbol_rank,
  input  logic              block_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] code_bits,
  output logic [LEN_W-1:0]  code_length,
  output logic              is_run_code,
  output logic              last_of_item,
  output logic              run_saturated
);

  state_t             state;
  state_t             state_next;
  logic [SYM_W-1:0]   sym_q;
  logic               end_q;
  logic               found_q;
  logic [POS_W-1:0]   pos_q;
  logic [RUN_V_W-1:0] run_value;
  logic [DIG_W-1:0]   run_digits;
  logic               run_over;

  list_ctrl_t         ctrl;
  logic               list_found;
  logic [POS_W-1:0]   list_pos;
  code_word_t         run_word;
  code_word_t         gamma_word;

  logic               in_accept;
  logic               out_free;
  logic               pending;
  logic               out_load;
  logic               out_last;
  code_word_t         out_word;
  logic               run_clear;
  logic               run_inc;

  assign in_ready  = (state == ST_IDLE) && !rst;
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign pending   = (run_digits != '0);

  assign ctrl.move    = (state == ST_MOVE) && found_q;
  assign ctrl.restore = (state == ST_FLUSH) && (!pending || out_free);

  mzrp_list u_list (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .pos       (pos_q),
    .cmp_sym   (symbol_rank),
    .ins_sym   (sym_q),
    .found     (list_found),
    .match_pos (list_pos)
  );

  mzrp_coder u_coder (
    .run_value  (run_value),
    .run_digits (run_digits),
    .run_over   (run_over),
    .pos        (pos_q),
    .run_word   (run_word),
    .gamma_word (gamma_word)
  );

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_last   = 1'b0;
    out_word   = gamma_word;
    run_clear  = 1'b0;
    run_inc    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_MOVE;
        end
      end
      ST_MOVE: begin
        run_inc = found_q && (pos_q == '0);
        if (found_q && (pos_q != '0)) begin
          state_next = pending ? ST_RUN : ST_GAMMA;
        end else if (end_q) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_word   = run_word;
          run_clear  = 1'b1;
          state_next = ST_GAMMA;
        end
      end
      ST_GAMMA: begin
        // The run is already clear here, so a block end adds no further code.
        if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          state_next = end_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!pending) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          out_word   = run_word;
          run_clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sym_q   <= symbol_rank;
      end_q   <= block_end;
      found_q <= list_found;
      pos_q   <= list_pos;
    end
  end

  // The run is held as count plus one together with its digit count, which
  // steps up whenever the value reaches a power of two.
  always_ff @(posedge clk) begin
    if (rst || run_clear) begin
      run_value  <= RUN_V_W'(1);
      run_digits <= '0;
      run_over   <= 1'b0;
    end else if (run_inc) begin
      if (run_value == RUN_FULL) begin
        run_over <= 1'b1;
      end else begin
        run_value <= run_value + RUN_V_W'(1);
        if ((run_value & (run_value + RUN_V_W'(1))) == '0) begin
          run_digits <= run_digits + DIG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      code_bits     <= out_word.bits;
      code_length   <= out_word.length;
      is_run_code   <= out_word.is_run;
      run_saturated <= out_word.sat;
      last_of_item  <= out_last;
    end
  end

endmodule

### tb/sv/mtf_zero_run_prefix_encoder_top_tb.sv
`timescale 1ns / 1ps

module mtf_zero_run_prefix_encoder_top_tb
  import mzrp_pkg::*;
();

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  length;
    logic              is_run;
    logic              last;
    logic              sat;
  } code_res_t;

  // One row of the directed table. Where typed is set, the code words are
  // given here and replace what the predictor works out for that symbol.
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic              blk_end;
    logic              typed;
    logic [1:0]        n_words;
    logic [CODE_W-1:0] bits0;
    logic [LEN_W-1:0]  len0;
    logic              run0;
    logic [CODE_W-1:0] bits1;
    logic [LEN_W-1:0]  len1;
    logic              run1;
  } step_row_t;

  localparam int N_DIRECTED = 24;
  localparam int PER_PHASE  = 382;
  localparam logic [RUN_COUNT_BITS-1:0] RUN_LIMIT = {RUN_COUNT_BITS{1'b1}};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [SYM_W-1:0]  symbol_rank = '0;
  logic              block_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              is_run_code;
  logic              last_of_item;
  logic              run_saturated;

  // Predictor state.
  logic [SYM_W-1:0]          mtf_list [ALPHABET_SIZE];
  logic [RUN_COUNT_BITS-1:0] run_cnt;
  logic                      run_ovf;

  code_res_t item_words [$];
  code_res_t exp_words [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int err_count = 0;
  int words_checked = 0;
  int run_words = 0;
  int symbols_sent = 0;
  longint longest_run = 0;

  step_row_t dir_rows [N_DIRECTED] = '{
    '{8'd0,   1'b0, 1'b1, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd0,   1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd255, 1'b0, 1'b1, 2'd2, 64'd3,   7'd2,  1'b1, 64'd256, 7'd17, 1'b0},
    '{8'd1,   1'b0, 1'b1, 2'd1, 64'd3,   7'd3,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd1,   1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd1,   1'b1, 1'b1, 2'd1, 64'd3,   7'd2,  1'b1, 64'd0,   7'd0,  1'b0},
    '{8'd128, 1'b1, 1'b1, 2'd1, 64'd129, 7'd15, 1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd0,   1'b1, 1'b1, 2'd1, 64'd2,   7'd2,  1'b1, 64'd0,   7'd0,  1'b0},
    '{8'd255, 1'b1, 1'b1, 2'd1, 64'd256, 7'd17, 1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd170, 1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd85,  1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd85,  1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd85,  1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd85,  1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd85,  1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd85,  1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd3,   1'b1, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd3,   1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd3,   1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd3,   1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd3,   1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd3,   1'b1, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd254, 1'b0, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0},
    '{8'd2,   1'b1, 1'b0, 2'd0, 64'd0,   7'd0,  1'b0, 64'd0,   7'd0,  1'b0}
  };

  mtf_zero_run_prefix_encoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .symbol_rank   (symbol_rank),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_bits     (code_bits),
    .code_length   (code_length),
    .is_run_code   (is_run_code),
    .last_of_item  (last_of_item),
    .run_saturated (run_saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int bit_width(input logic [63:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    if (err_count <= 100) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
  endtask

  task automatic restore_list();
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      mtf_list[i] = SYM_W'(i);
    end
  endtask

  // Each digit of count+1 below its top bit goes out as the pair 1,d,
  // least significant digit first.
  task automatic flush_run_code();
    logic [RUN_V_W-1:0] v;
    int nd;
    code_res_t w;
    v = RUN_V_W'(run_cnt) + 1'b1;
    nd = bit_width(64'(v)) - 1;
    w = '0;
    for (int i = 0; i < nd; i++) begin
      w.bits = (w.bits << 2) | 64'd2 | 64'(v[i]);
    end
    w.length = LEN_W'(2 * nd);
    w.is_run = 1'b1;
    w.sat = run_ovf;
    if (longint'(run_cnt) > longest_run) longest_run = longint'(run_cnt);
    item_words.insert(item_words.size(), w);
    run_cnt = '0;
    run_ovf = 1'b0;
  endtask

  task automatic code_symbol(input logic [SYM_W-1:0] sym, input logic bend);
    int pos;
    code_res_t w;
    item_words.delete();
    if (int'(sym) < ALPHABET_SIZE) begin
      pos = 0;
      while (pos < ALPHABET_SIZE && mtf_list[pos] != sym) pos++;
      if (pos < ALPHABET_SIZE) begin
        for (int j = pos; j > 0; j--) begin
          mtf_list[j] = mtf_list[j-1];
        end
        mtf_list[0] = sym;
        if (pos == 0) begin
          if (run_cnt == RUN_LIMIT) begin
            run_ovf = 1'b1;
          end else begin
            run_cnt = run_cnt + 1'b1;
          end
        end else begin
          if (run_cnt != 0 || run_ovf) flush_run_code();
          w = '0;
          w.bits = 64'(pos + 1);
          w.length = LEN_W'(2 * bit_width(64'(pos + 1)) - 1);
          item_words.insert(item_words.size(), w);
        end
      end
    end
    if (bend) begin
      if (run_cnt != 0 || run_ovf) flush_run_code();
      restore_list();
    end
    if (item_words.size() > 0) item_words[item_words.size()-1].last = 1'b1;
  endtask

  // Called at a rising edge; returns at the edge where the transaction is
  // accepted, with the predictor already advanced.
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic bend);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol_rank <= sym;
    block_end <= bend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    code_symbol(sym, bend);
    symbols_sent++;
  endtask

  task automatic wait_drained();
    if (exp_words.size() != 0) begin
      in_valid <= 1'b0;
      while (exp_words.size() != 0) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : check_words
    code_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (exp_words.size() == 0) begin
        report_mismatch("code word with none expected", code_bits, '0);
      end else begin
        want = exp_words[0];
        exp_words.delete(0);
        words_checked++;
        if (want.is_run) run_words++;
        if (code_bits !== want.bits) begin
          report_mismatch("code_bits", code_bits, want.bits);
        end
        if (code_length !== want.length) begin
          report_mismatch("code_length", 64'(code_length), 64'(want.length));
        end
        if (is_run_code !== want.is_run) begin
          report_mismatch("is_run_code", 64'(is_run_code), 64'(want.is_run));
        end
        if (last_of_item !== want.last) begin
          report_mismatch("last_of_item", 64'(last_of_item), 64'(want.last));
        end
        if (run_saturated !== want.sat) begin
          report_mismatch("run_saturated", 64'(run_saturated), 64'(want.sat));
        end
      end
    end
  end

  initial begin : stimulus
    step_row_t row;
    code_res_t w;
    logic [SYM_W-1:0] sym;
    int pick;
    int reps;
    int sent;

    restore_list();
    run_cnt = '0;
    run_ovf = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      row = dir_rows[r];
      send_symbol(row.sym, row.blk_end);
      if (row.typed) begin
        for (int k = 0; k < int'(row.n_words); k++) begin
          w = '0;
          w.bits = (k == 0) ? row.bits0 : row.bits1;
          w.length = (k == 0) ? row.len0 : row.len1;
          w.is_run = (k == 0) ? row.run0 : row.run1;
          w.last = (k == int'(row.n_words) - 1);
          exp_words.insert(exp_words.size(), w);
        end
      end else begin
        foreach (item_words[k]) exp_words.insert(exp_words.size(), item_words[k]);
      end
    end

    // Mostly repeats of the front symbol and near-front symbols, so that
    // runs build up and short gamma codes dominate; the rest is noise.
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      sent = 0;
      while (sent < PER_PHASE) begin
        pick = $urandom_range(99);
        reps = 1;
        if (pick < 35) begin
          reps = ($urandom_range(49) == 0) ? $urandom_range(250, 60) : $urandom_range(6, 1);
          sym = mtf_list[0];
        end else if (pick < 75) begin
          sym = mtf_list[$urandom_range(7, 1)];
        end else begin
          sym = SYM_W'($urandom_range(ALPHABET_SIZE - 1));
        end
        for (int k = 0; k < reps; k++) begin
          send_symbol(sym, $urandom_range(99) < 3);
          foreach (item_words[j]) exp_words.insert(exp_words.size(), item_words[j]);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    rx_stall_pct = 0;
    while (exp_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d symbols and %0d code words (%0d run codes, longest run %0d)",
             symbols_sent, words_checked, run_words, longest_run);
    $display("handshake mixes: free flow, sender gaps, receiver stalls, both; %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
